// ----- hdl/kse_pkg.sv -----
// ----------------------------------------------------------------------------
// kse_pkg
// Shared types, constants and marker tables of the keyed snippet extractor.
// ----------------------------------------------------------------------------
package kse_pkg;

    // Key capacity in bytes and marker lengths.
    localparam int KEY_BYTES   = 32;
    localparam int BEGIN_LEN   = 14;
    localparam int END_LEN     = 12;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Special characters.
    localparam logic [7:0] CHAR_NL   = 8'h0A;
    localparam logic [7:0] CHAR_HASH = 8'h23;

    // One command tells the back which results a single input byte causes:
    // a released end-marker prefix, then either the byte itself or a done.
    typedef struct packed {
        logic [3:0] prefix_len;
        logic       has_byte;
        logic       done;
        logic [7:0] data;
    } t_cmd;

    // Characters of the begin marker, in stream order.
    function automatic logic [7:0] begin_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "#";
            4'd1:    c = "B";
            4'd2:    c = "E";
            4'd3:    c = "G";
            4'd4:    c = "I";
            4'd5:    c = "N";
            4'd6:    c = "_";
            4'd7:    c = "S";
            4'd8:    c = "N";
            4'd9:    c = "I";
            4'd10:   c = "P";
            4'd11:   c = "P";
            4'd12:   c = "E";
            4'd13:   c = "T";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Characters of the end marker, in stream order.
    function automatic logic [7:0] end_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "#";
            4'd1:    c = "E";
            4'd2:    c = "N";
            4'd3:    c = "D";
            4'd4:    c = "_";
            4'd5:    c = "S";
            4'd6:    c = "N";
            4'd7:    c = "I";
            4'd8:    c = "P";
            4'd9:    c = "P";
            4'd10:   c = "E";
            4'd11:   c = "T";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/kse_in_if.sv -----
// ----------------------------------------------------------------------------
// kse_in_if
// Input byte channel: valid/ready handshake carrying one stream byte.
// ----------------------------------------------------------------------------
interface kse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- hdl/kse_out_if.sv -----
// ----------------------------------------------------------------------------
// kse_out_if
// Result channel: valid/ready handshake carrying one extracted result.
// ----------------------------------------------------------------------------
interface kse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       snippet_done;
    logic       last_of_run;

    modport source (output valid, output out_byte, output snippet_done,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input snippet_done,
                    input last_of_run, output ready);
endinterface

// ----- hdl/kse_front.sv -----
// ----------------------------------------------------------------------------
// kse_front
// Scans the byte stream, tracks markers and the snippet name, holds the
// key registers and issues one command per byte that causes results.
// ----------------------------------------------------------------------------
module kse_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    kse_in_if.sink           i_data,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [63:0]      i_cfg_data,
    input  logic             i_queue_full,
    output logic             o_push,
    output kse_pkg::t_cmd    o_cmd
);
    import kse_pkg::*;

    // Phase codes.
    localparam logic [1:0] PH_SEEK = 2'd0;
    localparam logic [1:0] PH_NAME = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;
    localparam logic [1:0] PH_TAIL = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] CFG_KEY_WORD0  = 3'd1;
    localparam logic [2:0] CFG_KEY_WORD3  = 3'd4;

    logic [5:0]        r_key_length;
    logic [3:0][63:0]  r_key_words;
    logic [1:0]        cfg_word_sel;

    logic [1:0] r_phase,    n_phase;
    logic [3:0] r_matched,  n_matched;
    logic [5:0] r_name_pos, n_name_pos;
    logic       r_differs,  n_differs;
    logic       r_selected, n_selected;
    logic       r_skip,     n_skip;

    logic       fire;
    logic [7:0] b;
    logic       is_hash;
    logic [7:0] key_char;
    logic [3:0] matched_inc;

    assign i_data.ready = !i_queue_full;
    assign fire         = i_data.valid && !i_queue_full;
    assign b            = i_data.data_byte;
    assign is_hash      = (b == CHAR_HASH);
    assign key_char     = r_key_words[r_name_pos[4:3]][{r_name_pos[2:0], 3'b000} +: 8];
    assign matched_inc  = r_matched + 4'd1;
    assign cfg_word_sel = 2'(i_cfg_index - CFG_KEY_WORD0);

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= '0;
            r_key_words  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_KEY_LENGTH) begin
                r_key_length <= i_cfg_data[5:0];
            end else if (i_cfg_index <= CFG_KEY_WORD3) begin
                r_key_words[cfg_word_sel] <= i_cfg_data;
            end
        end
    end

    // Scanner next state and command generation.
    always_comb begin
        n_phase    = r_phase;
        n_matched  = r_matched;
        n_name_pos = r_name_pos;
        n_differs  = r_differs;
        n_selected = r_selected;
        n_skip     = r_skip;
        o_push     = 1'b0;
        o_cmd      = '0;
        o_cmd.data = b;

        if (fire) begin
            if (r_skip) begin
                n_skip = 1'b0;
            end else begin
                case (r_phase)
                    PH_SEEK: begin
                        if (b == begin_char(r_matched)) begin
                            n_matched = matched_inc;
                        end else begin
                            n_matched = {3'b000, is_hash};
                        end
                        if (n_matched == 4'(BEGIN_LEN)) begin
                            n_phase    = PH_NAME;
                            n_matched  = '0;
                            n_name_pos = '0;
                            n_differs  = 1'b0;
                            n_skip     = 1'b1;
                        end
                    end
                    PH_NAME: begin
                        if (b == CHAR_NL) begin
                            n_selected = !r_differs && (r_name_pos == r_key_length);
                            n_phase    = PH_BODY;
                            n_matched  = '0;
                        end else begin
                            if (r_name_pos >= 6'(KEY_BYTES) ||
                                r_name_pos >= r_key_length ||
                                b != key_char) begin
                                n_differs = 1'b1;
                            end
                            if (r_name_pos != 6'd63) begin
                                n_name_pos = r_name_pos + 6'd1;
                            end
                        end
                    end
                    PH_BODY: begin
                        if (b == end_char(r_matched)) begin
                            n_matched = matched_inc;
                            if (matched_inc == 4'(END_LEN)) begin
                                o_push     = r_selected;
                                o_cmd.done = 1'b1;
                                o_cmd.data = 8'h00;
                                n_phase    = PH_TAIL;
                                n_matched  = '0;
                                n_skip     = 1'b1;
                            end
                        end else begin
                            // Release the held prefix, then the byte unless it
                            // starts a new marker.
                            o_push           = r_selected && (r_matched != 4'd0 || !is_hash);
                            o_cmd.prefix_len = r_matched;
                            o_cmd.has_byte   = !is_hash;
                            n_matched        = {3'b000, is_hash};
                        end
                    end
                    PH_TAIL: begin
                        if (b == CHAR_NL) begin
                            n_phase   = PH_SEEK;
                            n_matched = '0;
                        end
                    end
                    default: begin
                        n_phase = PH_SEEK;
                    end
                endcase
            end
        end
    end

    // Scanner state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SEEK;
            r_matched  <= '0;
            r_name_pos <= '0;
            r_differs  <= 1'b0;
            r_selected <= 1'b0;
            r_skip     <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_matched  <= n_matched;
            r_name_pos <= n_name_pos;
            r_differs  <= n_differs;
            r_selected <= n_selected;
            r_skip     <= n_skip;
        end
    end

endmodule

// ----- hdl/kse_queue.sv -----
// ----------------------------------------------------------------------------
// kse_queue
// Short command FIFO that decouples the scanner from the result expander.
// ----------------------------------------------------------------------------
module kse_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kse_pkg::t_cmd    i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_head_valid,
    output kse_pkg::t_cmd    o_head
);
    import kse_pkg::*;

    t_cmd                   r_slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full       = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slots[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QUEUE_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

// ----- hdl/kse_back.sv -----
// ----------------------------------------------------------------------------
// kse_back
// Expands each command into its results, one per cycle while the output is
// accepted, into a registered output stage.
// ----------------------------------------------------------------------------
module kse_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  kse_pkg::t_cmd    i_head,
    output logic             o_pop,
    kse_out_if.source        o_result
);
    import kse_pkg::*;

    logic [3:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_done;
    logic       r_last;

    logic       advance;
    logic       emit;
    logic [3:0] last_idx;
    logic       is_last;
    logic       in_prefix;

    assign advance   = !r_valid || o_result.ready;
    assign emit      = advance && i_head_valid;
    assign last_idx  = i_head.prefix_len + {3'b000, i_head.has_byte | i_head.done} - 4'd1;
    assign is_last   = (r_idx == last_idx);
    assign in_prefix = (r_idx < i_head.prefix_len);
    assign o_pop     = emit && is_last;

    assign o_result.valid        = r_valid;
    assign o_result.out_byte     = r_byte;
    assign o_result.snippet_done = r_done;
    assign o_result.last_of_run  = r_last;

    // Position within the current command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (emit) begin
            r_idx <= is_last ? 4'd0 : r_idx + 4'd1;
        end
    end

    // Output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_head_valid;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_last <= is_last;
            if (in_prefix) begin
                r_byte <= end_char(r_idx);
                r_done <= 1'b0;
            end else if (i_head.done) begin
                r_byte <= 8'h00;
                r_done <= 1'b1;
            end else begin
                r_byte <= i_head.data;
                r_done <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/keyed_snippet_extractor_top.sv -----
// Latency: a result is registered in the command queue, then in the output stage.
// Throughput: one input byte per cycle while the command queue has room; a
// byte that releases a held end-marker prefix expands into up to 12 results
// in the result expander, while the queue absorbs further bytes.
// Reset: synchronous active-low i_rst_n clears scanner state, key registers,
// the queue and the output stage; no clearing pass is needed.
// ----------------------------------------------------------------------------
// keyed_snippet_extractor_top
// Streams the body of the snippet whose name equals the configured key.
// ----------------------------------------------------------------------------
module keyed_snippet_extractor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kse_in_if.sink      i_data,
    kse_out_if.source   o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import kse_pkg::*;

    logic push;
    t_cmd cmd;
    logic queue_full;
    logic pop;
    logic head_valid;
    t_cmd head;

    // Scanner and command generation.
    kse_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_data       (i_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (cmd)
    );

    // Command queue.
    kse_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (cmd),
        .o_full       (queue_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // Result expansion.
    kse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_result     (o_result)
    );

endmodule

// ----- verif/keyed_snippet_extractor_top_test.sv -----
// ----------------------------------------------------------------------------
// keyed_snippet_extractor_top_test
// Streams text bytes into the snippet extractor under several key settings.
// A scanner kept in step with the design predicts every released byte and
// done request, and a monitor checks them in order, field by field.
// ----------------------------------------------------------------------------
module keyed_snippet_extractor_top_test;
    import kse_pkg::*;

    // Scanner phases, in the order the stream moves through them.
    typedef enum logic [1:0] {
        SEEK_BEGIN,
        READ_NAME,
        PASS_BODY,
        SKIP_END_LINE
    } t_scan_phase;

    // Register indexes of the write port; the last two lie past the list.
    localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] REG_KEY_LOW    = 3'd1;
    localparam logic [2:0] REG_KEY_SECOND = 3'd2;
    localparam logic [2:0] REG_KEY_THIRD  = 3'd3;
    localparam logic [2:0] REG_KEY_HIGH   = 3'd4;
    localparam logic [2:0] REG_SPARE      = 3'd5;
    localparam logic [2:0] REG_LAST_INDEX = 3'd7;

    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       snippet_done;
        logic       last_of_run;
    } t_release;

    // Clock, reset and design inputs, all known from time zero.
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [2:0]  cfg_index  = '0;
    logic [63:0] cfg_data   = '0;
    logic        send_valid = 1'b0;
    logic [7:0]  send_byte  = '0;
    logic        take_ready = 1'b0;

    kse_in_if  byte_if ();
    kse_out_if release_if ();

    assign byte_if.valid     = send_valid;
    assign byte_if.data_byte = send_byte;
    assign release_if.ready  = take_ready;

    keyed_snippet_extractor_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (byte_if),
        .o_result    (release_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Scanner copy of the key registers and state.
    logic [5:0]  key_len_reg     = '0;
    logic [63:0] key_word_reg [4] = '{default: 64'h0};
    t_scan_phase scan_phase      = SEEK_BEGIN;
    logic [3:0]  marks_seen      = '0;
    logic [5:0]  name_pos        = '0;
    logic        name_mismatch   = 1'b0;
    logic        name_selected   = 1'b0;
    logic        drop_next       = 1'b0;

    // Stimulus side: pending bytes and the key the names are built from.
    logic [7:0]  text_q [$];
    t_release    pending_releases [$];
    logic [7:0]  key_text [KEY_BYTES];
    int          key_size        = 0;
    int          queued_total    = 0;
    bit          idle_allowed    = 1'b1;

    // Bookkeeping shared by the monitor and the summary.
    int          hold_requests     = 0;
    int          holds_served      = 0;
    int          hold_left         = 0;
    int          stall_left        = 0;
    int          gap_left          = 0;
    int          failures          = 0;
    int          quiet_cycles      = 0;
    int          bytes_accepted    = 0;
    int          results_checked   = 0;
    int          snippets_released = 0;
    int          key_settings      = 0;
    t_release    want;

    function automatic logic [7:0] begin_at(input int idx);
        return begin_char(4'(idx));
    endfunction

    function automatic logic [7:0] end_at(input int idx);
        return end_char(4'(idx));
    endfunction

    function automatic logic [7:0] key_at(input logic [5:0] idx);
        return key_word_reg[idx[4:3]][8*idx[2:0] +: 8];
    endfunction

    // Advance the scanner by one accepted byte and queue what it releases.
    task automatic scan_byte(input logic [7:0] b);
        logic [7:0] rel_byte [12];
        logic       rel_done [12];
        t_release   item;
        int         n;
        int         k;
        n = 0;
        if (drop_next) begin
            drop_next = 1'b0;
        end else begin
            case (scan_phase)
                SEEK_BEGIN: begin
                    if (marks_seen < BEGIN_LEN && b == begin_at(marks_seen)) begin
                        marks_seen = marks_seen + 4'd1;
                    end else begin
                        marks_seen = (b == CHAR_HASH) ? 4'd1 : 4'd0;
                    end
                    if (marks_seen >= BEGIN_LEN) begin
                        scan_phase    = READ_NAME;
                        marks_seen    = '0;
                        name_pos      = '0;
                        name_mismatch = 1'b0;
                        drop_next     = 1'b1;
                    end
                end
                READ_NAME: begin
                    if (b == CHAR_NL) begin
                        name_selected = !name_mismatch && (name_pos == key_len_reg);
                        scan_phase    = PASS_BODY;
                        marks_seen    = '0;
                    end else begin
                        // Bytes past the key or past the capacity never match.
                        if (name_pos >= KEY_BYTES || name_pos >= key_len_reg ||
                            b != key_at(name_pos)) begin
                            name_mismatch = 1'b1;
                        end
                        if (name_pos < 6'd63) begin
                            name_pos = name_pos + 6'd1;
                        end
                    end
                end
                PASS_BODY: begin
                    if (marks_seen < END_LEN && b == end_at(marks_seen)) begin
                        marks_seen = marks_seen + 4'd1;
                        if (marks_seen >= END_LEN) begin
                            if (name_selected) begin
                                rel_byte[n] = 8'h00;
                                rel_done[n] = 1'b1;
                                n++;
                            end
                            scan_phase = SKIP_END_LINE;
                            marks_seen = '0;
                            drop_next  = 1'b1;
                        end
                    end else begin
                        // A broken end marker releases its held prefix first.
                        if (name_selected) begin
                            for (k = 0; k < marks_seen; k++) begin
                                rel_byte[n] = end_at(k);
                                rel_done[n] = 1'b0;
                                n++;
                            end
                            if (b != CHAR_HASH) begin
                                rel_byte[n] = b;
                                rel_done[n] = 1'b0;
                                n++;
                            end
                        end
                        marks_seen = (b == CHAR_HASH) ? 4'd1 : 4'd0;
                    end
                end
                default: begin
                    if (b == CHAR_NL) begin
                        scan_phase = SEEK_BEGIN;
                        marks_seen = '0;
                    end
                end
            endcase
        end
        for (k = 0; k < n; k++) begin
            item.out_byte     = rel_byte[k];
            item.snippet_done = rel_done[k];
            item.last_of_run  = (k == n - 1);
            pending_releases.push_back(item);
        end
    endtask

    // One register write, mirrored into the scanner's copy.
    task automatic write_register(input logic [2:0] index, input logic [63:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            REG_KEY_LENGTH: key_len_reg = value[5:0];
            REG_KEY_LOW, REG_KEY_SECOND, REG_KEY_THIRD, REG_KEY_HIGH:
                key_word_reg[2'(index - REG_KEY_LOW)] = value;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Pack key_text into the four key words and write all key registers.
    task automatic load_key(input int size);
        logic [63:0] words [4];
        int          i;
        for (i = 0; i < KEY_BYTES; i++) begin
            words[i / 8][8*(i % 8) +: 8] = key_text[i];
        end
        key_size = size;
        key_settings++;
        write_register(REG_KEY_LENGTH, 64'(size));
        write_register(REG_KEY_LOW, words[0]);
        write_register(REG_KEY_SECOND, words[1]);
        write_register(REG_KEY_THIRD, words[2]);
        write_register(REG_KEY_HIGH, words[3]);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_NL) begin
            b = 8'h0B;
        end
        return b;
    endfunction

    // Stray bytes between snippets, rich in begin-marker characters.
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0:       b = CHAR_HASH;
            1:       b = begin_at($urandom_range(1, BEGIN_LEN - 1));
            2:       b = CHAR_NL;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // Body bytes, rich in end-marker characters.
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0, 1:    b = CHAR_HASH;
            2, 3:    b = end_at($urandom_range(1, END_LEN - 1));
            4:       b = CHAR_NL;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        text_q.push_back(b);
        queued_total++;
    endtask

    task automatic queue_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            queue_byte(s[i]);
        end
    endtask

    task automatic queue_begin(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            queue_byte(begin_at(i));
        end
    endtask

    task automatic queue_end(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            queue_byte(end_at(i));
        end
    endtask

    // One well-formed snippet with random content, sometimes with a broken
    // begin marker in front and a name that is near the key but not it.
    task automatic add_snippet(input bit named_by_key);
        logic [7:0] name_q [$];
        int         count;
        int         i;
        int         pos;
        count = $urandom_range(0, 4);
        for (i = 0; i < count; i++) begin
            queue_byte(noise_byte());
        end
        if ($urandom_range(0, 7) == 0) begin
            queue_begin($urandom_range(1, BEGIN_LEN - 1));
            queue_byte(noise_byte());
        end
        queue_begin(BEGIN_LEN);
        queue_byte(8'($urandom_range(0, 255)));
        for (i = 0; i < key_size; i++) begin
            name_q.push_back(i < KEY_BYTES ? key_text[i] : text_byte());
        end
        if (!named_by_key) begin
            case ($urandom_range(0, 3))
                0: begin
                    name_q.delete();
                    count = $urandom_range(0, 6);
                    for (i = 0; i < count; i++) begin
                        name_q.push_back(text_byte());
                    end
                end
                1: begin
                    if (name_q.size() > 0) begin
                        pos = $urandom_range(0, name_q.size() - 1);
                        name_q[pos] = name_q[pos] ^ 8'h80;
                        if (name_q[pos] == CHAR_NL) begin
                            name_q[pos] = 8'h0B;
                        end
                    end
                end
                2: name_q.push_back(text_byte());
                default: begin
                    if (name_q.size() > 0) begin
                        void'(name_q.pop_back());
                    end
                end
            endcase
        end
        foreach (name_q[j]) begin
            queue_byte(name_q[j]);
        end
        queue_byte(CHAR_NL);
        count = $urandom_range(0, 16);
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                queue_end($urandom_range(1, END_LEN - 1));
            end else begin
                queue_byte(body_byte());
            end
        end
        queue_end(END_LEN);
        queue_byte(($urandom_range(0, 5) == 0) ? CHAR_NL : 8'($urandom_range(0, 255)));
        count = $urandom_range(0, 3);
        for (i = 0; i < count; i++) begin
            queue_byte(text_byte());
        end
        queue_byte(CHAR_NL);
    endtask

    task automatic stream_random(input int budget, input bit lead_with_key);
        int start;
        start = queued_total;
        if (lead_with_key) begin
            add_snippet(1'b1);
        end
        while (queued_total - start < budget) begin
            add_snippet(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic random_key_text();
        int i;
        for (i = 0; i < KEY_BYTES; i++) begin
            key_text[i] = text_byte();
        end
    endtask

    // Wait until every byte is in and every release is out, then let the
    // design finish bytes that cause no release.
    task automatic settle();
        @(negedge i_clk);
        while (text_q.size() != 0 || send_valid || pending_releases.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Byte sender: offers queued bytes, with random gap bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            send_valid <= 1'b0;
            gap_left   <= 0;
        end else if (!send_valid || byte_if.ready) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                send_valid <= 1'b0;
            end else if (idle_allowed && text_q.size() != 0 &&
                         $urandom_range(0, 9) == 0) begin
                gap_left   <= $urandom_range(0, 6);
                send_valid <= 1'b0;
            end else if (text_q.size() != 0) begin
                send_valid <= 1'b1;
                send_byte  <= text_q.pop_front();
            end else begin
                send_valid <= 1'b0;
            end
        end
    end

    // Release receiver: random stall bursts and the long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            take_ready <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            take_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES - 1;
            take_ready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            take_ready <= 1'b0;
        end else if (idle_allowed && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 6);
            take_ready <= 1'b0;
        end else begin
            take_ready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted byte, check each accepted release,
    // and end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready) begin
                scan_byte(byte_if.data_byte);
                bytes_accepted++;
            end
            if (release_if.valid && release_if.ready) begin
                if (pending_releases.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("Unexpected release: byte=%02h done=%0b last=%0b",
                                 release_if.out_byte, release_if.snippet_done,
                                 release_if.last_of_run);
                    end
                end else begin
                    want = pending_releases.pop_front();
                    if (want.out_byte !== release_if.out_byte ||
                        want.snippet_done !== release_if.snippet_done ||
                        want.last_of_run !== release_if.last_of_run) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $display({"Release %0d differs: expected byte=%02h done=%0b ",
                                      "last=%0b, got byte=%02h done=%0b last=%0b"},
                                     results_checked, want.out_byte, want.snippet_done,
                                     want.last_of_run, release_if.out_byte,
                                     release_if.snippet_done, release_if.last_of_run);
                        end
                    end
                    if (want.snippet_done) begin
                        snippets_released++;
                    end
                    results_checked++;
                end
            end
            if ((byte_if.valid && byte_if.ready) ||
                (release_if.valid && release_if.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no request moved for %0d cycles, %0d releases outstanding",
                         quiet_cycles, pending_releases.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int i;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short key; writes past the register list must change nothing.
        random_key_text();
        key_text[0] = "a";
        key_text[1] = "b";
        load_key(2);
        write_register(REG_SPARE, '1);
        write_register(REG_LAST_INDEX, 64'h5A5A_A5A5_0F0F_F0F0);
        @(negedge i_clk);
        // Doubled hash before the begin marker, broken end markers with a
        // full-length held prefix, byte extremes, and a hash after a hash.
        queue_text("x#");
        queue_begin(BEGIN_LEN);
        queue_text(" ab\n");
        queue_text("a#b#");
        queue_end(5);
        queue_end(END_LEN - 1);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_text("\n");
        queue_end(END_LEN);
        queue_text(" ab\n");
        // Name too long; the newline after the end marker is dropped, so the
        // following line, begin marker and all, is skipped.
        queue_begin(BEGIN_LEN);
        queue_text(" abc\nq#r");
        queue_end(END_LEN);
        queue_text("\nskip ");
        queue_begin(BEGIN_LEN);
        queue_text(" ab\n");
        queue_begin(BEGIN_LEN);
        queue_text(" ab\nok");
        queue_end(END_LEN);
        queue_text("\n");
        settle();

        // Random key of five bytes; the receiver holds off while a selected
        // snippet with a long body arrives, so the design fills up and
        // stalls its input.
        random_key_text();
        load_key(5);
        @(negedge i_clk);
        hold_requests++;
        queue_begin(BEGIN_LEN);
        queue_text(" ");
        for (i = 0; i < 5; i++) begin
            queue_byte(key_text[i]);
        end
        queue_byte(CHAR_NL);
        for (i = 0; i < 20; i++) begin
            queue_byte(8'(8'h61 + i));
        end
        queue_end(END_LEN);
        queue_text(" \n");
        settle();

        // Key at full capacity with every key bit set.
        for (i = 0; i < KEY_BYTES; i++) begin
            key_text[i] = 8'hFF;
        end
        load_key(KEY_BYTES);
        @(negedge i_clk);
        queue_begin(BEGIN_LEN);
        queue_text(" ");
        for (i = 0; i < KEY_BYTES; i++) begin
            queue_byte(8'hFF);
        end
        queue_text("\nfull");
        queue_end(END_LEN);
        queue_text(" \n");
        settle();

        // Empty key with all key bits clear: only an empty name matches.
        for (i = 0; i < KEY_BYTES; i++) begin
            key_text[i] = 8'h00;
        end
        load_key(0);
        @(negedge i_clk);
        queue_begin(BEGIN_LEN);
        queue_text(" \nE#\n");
        queue_end(END_LEN);
        queue_text(" \n");
        queue_begin(BEGIN_LEN);
        queue_text(" z\nno");
        queue_end(END_LEN);
        queue_text(" z\n");
        settle();

        // Key length beyond capacity: nothing can match, and a very long
        // name drives the name position into saturation.
        random_key_text();
        load_key(63);
        @(negedge i_clk);
        queue_begin(BEGIN_LEN);
        queue_text(" ");
        for (i = 0; i < 66; i++) begin
            queue_byte("n");
        end
        queue_text("\nzz");
        queue_end(END_LEN);
        queue_text(" x\n");
        settle();

        // Closing stretch at full rate on both sides.
        @(negedge i_clk);
        idle_allowed = 1'b0;
        random_key_text();
        load_key($urandom_range(1, 8));
        @(negedge i_clk);
        stream_random(60, 1'b1);
        settle();

        $display("Streamed %0d bytes under %0d key settings; %0d releases checked.",
                 bytes_accepted, key_settings, results_checked);
        $display("Selected snippets closed: %0d; long receiver hold-offs: %0d.",
                 snippets_released, hold_requests);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Mismatches: %0d", failures);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
